/* design/keyed_quantity_table_defines.svh */
// Assertion macros shared by the keyed quantity table RTL.
// Included by keyed_quantity_table, which carries the concurrent checks; needs nothing else.
`ifndef KEYED_QUANTITY_TABLE_DEFINES_SVH
`define KEYED_QUANTITY_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define KQT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset.
`define KQT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/kqt_pkg.sv */
// Shared types and constants of the keyed quantity table.
// Stands alone; used by keyed_quantity_table (the slot RAM is generic).
package kqt_pkg;

   localparam int SLOTS   = 8;
   localparam int KEY_W   = 16;
   localparam int AMT_W   = 16;
   localparam int QTY_W   = 24;
   localparam int STAT_W  = 2;
   localparam int USED_W  = 4;
   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int NXT_W   = CNT_W + 1;
   localparam int ENTRY_W = KEY_W + QTY_W;

   localparam logic [QTY_W-1:0] QTY_MAX = {QTY_W{1'b1}};

   // command codes
   localparam logic ACT_ADD    = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   // status codes
   localparam logic [STAT_W-1:0] ST_ADDED   = 2'd0;
   localparam logic [STAT_W-1:0] ST_REMOVED = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STAT_W-1:0] ST_SHORT   = 2'd3;

   typedef struct packed {
      logic             action;
      logic [KEY_W-1:0] item_key;
      logic [AMT_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [QTY_W-1:0]  quantity_now;
      logic [USED_W-1:0] slots_used;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [QTY_W-1:0] qty;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_DECIDE,
      S_SHIFT,
      S_DONE
   } kqt_state_type;

endpackage

/* design/kqt_slot_ram.sv */
// Slot storage: simple dual-port synchronous RAM, one write and one read port.
// Read data is registered. Generic, no package needed.
module kqt_slot_ram #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 40
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/keyed_quantity_table.sv */
// Keyed quantity table: up to SLOTS (key, quantity) slots in insertion order.
// Channels: req_ carries one command item (add or remove an amount for a key),
// rsp_ returns exactly one result item per command (status, quantity held for
// the key afterwards, occupied slot count). Both use valid/stall; an item moves
// on a rising edge with valid high and stall low.
// Steps: accept; search, reading the slot RAM once per cycle from slot 0 until
// the key is hit or the used slots are exhausted (skipped if the table is empty);
// decide/write; compaction, one slot moved per cycle, after a removal that empties
// a slot other than the last occupied one; result hand-off.
// One command is in flight at a time; req_stall is high from acceptance until
// the result sits in the output register.
// The output register frees the table: a new command can be accepted while the
// previous result still waits on rsp_stall; a finished command then holds in
// the hand-off state until that register drains.
// Reset (synchronous, active high) empties the table (used count 0) and drops
// rsp_valid. Slot contents are not cleared; only slots below the used count
// are ever read.
// Depends on kqt_pkg, kqt_slot_ram and keyed_quantity_table_defines.svh.
`include "keyed_quantity_table_defines.svh"

module keyed_quantity_table
   import kqt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   // control state
   kqt_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // command context and search result
   req_type          cmd_ff, cmd_in;
   logic [IDX_W-1:0] src_ff, src_in;     // address whose read data arrives next
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [QTY_W-1:0] hit_qty_ff, hit_qty_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff, rsp_in;

   // slot RAM port
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   entry_type        ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   entry_type        ram_rdata;

   kqt_slot_ram #(
      .DEPTH (SLOTS),
      .WIDTH (ENTRY_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // decision terms
   logic             req_fire;
   logic             out_free;
   logic             key_match;
   logic             search_more;
   logic             shift_more;
   logic             has_room;
   logic             enough;
   logic             need_shift;
   logic [QTY_W:0]   sum_wide;
   logic [QTY_W-1:0] sum_sat;
   logic [QTY_W-1:0] diff;

   assign req_fire    = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign key_match   = (ram_rdata.key == cmd_ff.item_key);
   assign search_more = (NXT_W'(src_ff) + NXT_W'(1)) < NXT_W'(cnt_ff);
   // cnt_ff already holds the reduced count while compacting; the last
   // source slot is the one at that count
   assign shift_more  = NXT_W'(src_ff) < NXT_W'(cnt_ff);
   assign has_room    = NXT_W'(cnt_ff) < NXT_W'(SLOTS);
   assign sum_wide    = {1'b0, hit_qty_ff} + (QTY_W + 1)'(cmd_ff.amount);
   assign sum_sat     = sum_wide[QTY_W] ? QTY_MAX : sum_wide[QTY_W-1:0];
   assign enough      = hit_qty_ff >= QTY_W'(cmd_ff.amount);
   assign diff        = hit_qty_ff - QTY_W'(cmd_ff.amount);
   assign need_shift  = (cmd_ff.action == ACT_REMOVE) && hit_ff && enough
                        && (diff == '0)
                        && ((NXT_W'(hit_idx_ff) + NXT_W'(1)) < NXT_W'(cnt_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = (cnt_ff == '0) ? S_DECIDE : S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (key_match || !search_more) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = need_shift ? S_SHIFT : S_DONE;
         end
         S_SHIFT: begin
            if (!shift_more) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and RAM control
   always_comb begin
      ram_we       = 1'b0;
      ram_waddr    = hit_idx_ff;
      ram_wdata    = '{key: cmd_ff.item_key, qty: sum_sat};
      ram_raddr    = src_ff;
      cmd_in       = cmd_ff;
      src_in       = src_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_qty_in   = hit_qty_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_payload;
               hit_in    = 1'b0;
               src_in    = '0;
               ram_raddr = '0;
            end
         end
         S_SEARCH: begin
            if (key_match) begin
               hit_in     = 1'b1;
               hit_idx_in = src_ff;
               hit_qty_in = ram_rdata.qty;
            end else if (search_more) begin
               src_in    = IDX_W'(NXT_W'(src_ff) + NXT_W'(1));
               ram_raddr = IDX_W'(NXT_W'(src_ff) + NXT_W'(1));
            end
         end
         S_DECIDE: begin
            res_in.quantity_now = '0;
            if (cmd_ff.action == ACT_ADD) begin
               if (hit_ff) begin
                  ram_we              = 1'b1;
                  res_in.status       = ST_ADDED;
                  res_in.quantity_now = sum_sat;
               end else if (has_room) begin
                  ram_we              = 1'b1;
                  ram_waddr           = cnt_ff[IDX_W-1:0];
                  ram_wdata.qty       = QTY_W'(cmd_ff.amount);
                  cnt_in              = cnt_ff + CNT_W'(1);
                  res_in.status       = ST_ADDED;
                  res_in.quantity_now = QTY_W'(cmd_ff.amount);
               end else begin
                  res_in.status = ST_FULL;
               end
            end else begin
               if (!hit_ff) begin
                  res_in.status = ST_SHORT;
               end else if (!enough) begin
                  res_in.status       = ST_SHORT;
                  res_in.quantity_now = hit_qty_ff;
               end else begin
                  res_in.status       = ST_REMOVED;
                  res_in.quantity_now = diff;
                  if (diff != '0) begin
                     ram_we        = 1'b1;
                     ram_wdata.qty = diff;
                  end else begin
                     cnt_in = cnt_ff - CNT_W'(1);
                     // start compaction: fetch the slot after the emptied one
                     if (need_shift) begin
                        src_in    = IDX_W'(NXT_W'(hit_idx_ff) + NXT_W'(1));
                        ram_raddr = IDX_W'(NXT_W'(hit_idx_ff) + NXT_W'(1));
                     end
                  end
               end
            end
            res_in.slots_used = USED_W'(cnt_in);
         end
         S_SHIFT: begin
            // move slot src down one place, prefetch the next one
            ram_we    = 1'b1;
            ram_waddr = IDX_W'(NXT_W'(src_ff) - NXT_W'(1));
            ram_wdata = ram_rdata;
            if (shift_more) begin
               src_in    = IDX_W'(NXT_W'(src_ff) + NXT_W'(1));
               ram_raddr = IDX_W'(NXT_W'(src_ff) + NXT_W'(1));
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      src_ff     <= src_in;
      hit_ff     <= hit_in;
      hit_idx_ff <= hit_idx_in;
      hit_qty_ff <= hit_qty_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   `KQT_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1,
      NXT_W'(cnt_ff) <= NXT_W'(SLOTS), "used count beyond table size")
   `KQT_ASSERT_NOW(a_search_in_range, clock, reset, state_ff == S_SEARCH,
      NXT_W'(src_ff) < NXT_W'(cnt_ff), "search reads an unoccupied slot")
   `KQT_ASSERT_NOW(a_shift_in_range, clock, reset, state_ff == S_SHIFT,
      (src_ff != '0) && (NXT_W'(src_ff) <= NXT_W'(cnt_ff)),
      "compaction source outside occupied slots")
   `KQT_ASSERT_NEXT(a_cnt_only_on_decide, clock, reset, state_ff != S_DECIDE,
      $stable(cnt_ff), "used count changed outside the decide step")
   `KQT_ASSERT_NEXT(a_accept_starts_work, clock, reset, req_fire,
      (state_ff == S_SEARCH) || (state_ff == S_DECIDE),
      "accepted item did not start a lookup")

endmodule
